// File: design/irm_pkg.sv
// Shared constants, types and control codes of the interface rate meter.
package irm_pkg;

    // Number of interface entries in the sample store.
    localparam int NUM_PORTS = 32;
    localparam int PORT_AW   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int PORT_W    = 5;

    // Counter and rate word widths.
    localparam int WORD_W = 64;
    localparam int OVH_W  = 8;
    localparam int IVL_W  = 12;

    // Digit-serial datapath: byte digits for add and multiply passes.
    localparam int DIG_W      = 8;
    localparam int DIGITS     = WORD_W / DIG_W;
    localparam int WRAP_DIGIT = 32 / DIG_W;
    localparam int PROD_W     = DIG_W + 1 + OVH_W;
    localparam int CARRY_W    = 10;
    localparam int ACC_W      = DIG_W + CARRY_W;

    // Divider: quotient bits produced per cycle.
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = WORD_W / DIV_BITS;

    // Step counter covers the longest pass.
    localparam int CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes and reset values.
    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] REG_OVERHEAD = 2'd0;
    localparam logic [CFG_AW-1:0] REG_INTERVAL = 2'd1;
    localparam logic [OVH_W-1:0]  OVERHEAD_RST = 8'd24;
    localparam logic [IVL_W-1:0]  INTERVAL_RST = 12'd3;

    // One stored sample of an interface.
    typedef struct packed {
        logic [WORD_W-1:0] rx_bytes;
        logic [WORD_W-1:0] rx_packets;
        logic [WORD_W-1:0] tx_bytes;
        logic [WORD_W-1:0] tx_packets;
    } sample_t;

    // Pass controls from the sequencer to each direction lane.
    typedef struct packed {
        logic load_cur;
        logic load_old;
        logic sub_en;
        logic mul_en;
        logic div_en;
        logic wrap_dig;
    } lane_ctl_t;

endpackage

// File: design/irm_store.sv
// Per-interface sample memory with seen marks.
module irm_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      access,
    input  logic [irm_pkg::PORT_AW-1:0] addr,
    input  irm_pkg::sample_t          wdata,
    output irm_pkg::sample_t          rdata,
    output logic                      seen
);
    import irm_pkg::*;

    sample_t                mem [NUM_PORTS];
    sample_t                raw_reg;
    logic [NUM_PORTS-1:0]   seen_reg;
    logic                   hit_reg;

    // Read the old sample and write the new one in the same cycle.
    always_ff @(posedge clk)
    begin
        if (access)
        begin
            raw_reg   <= mem[addr];
            mem[addr] <= wdata;
        end
    end

    // Seen marks double as valid bits: an unseen entry reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else if (access)
        begin
            hit_reg        <= seen_reg[addr];
            seen_reg[addr] <= 1'b1;
        end
    end

    assign rdata = hit_reg ? raw_reg : '0;
    assign seen  = hit_reg;

endmodule

// File: design/irm_lane.sv
// One direction of the rate datapath: serial subtract, multiply-add and divide.
module irm_lane (
    input  logic                          clk,
    input  irm_pkg::lane_ctl_t            ctl,
    input  logic [irm_pkg::WORD_W-1:0]    cur_bytes,
    input  logic [irm_pkg::WORD_W-1:0]    cur_packets,
    input  logic [irm_pkg::WORD_W-1:0]    old_bytes,
    input  logic [irm_pkg::WORD_W-1:0]    old_packets,
    input  logic signed [irm_pkg::OVH_W-1:0] overhead,
    input  logic [irm_pkg::IVL_W-1:0]     divisor,
    output logic [irm_pkg::WORD_W-1:0]    pkt_word,
    output logic [irm_pkg::WORD_W-1:0]    byte_word
);
    import irm_pkg::*;

    logic [WORD_W-1:0]        pkt_reg;
    logic [WORD_W-1:0]        byte_reg;
    logic [WORD_W-1:0]        old_pkt_reg;
    logic [WORD_W-1:0]        old_byte_reg;
    logic                     bor_p_reg;
    logic                     bor_b_reg;
    logic                     c1_reg;
    logic [CARRY_W-1:0]       c2_reg;
    logic [IVL_W-1:0]         rem_reg;

    logic [DIG_W:0]           sub_p;
    logic [DIG_W:0]           sub_b;
    logic [DIG_W:0]           pinc;
    logic signed [PROD_W-1:0] prod;
    logic [ACC_W-1:0]         acc;
    logic [IVL_W-1:0]         rem_next;
    logic [IVL_W-1:0]         rem_tmp;
    logic [IVL_W:0]           rem_sh;
    logic [DIV_BITS-1:0]      quo_bits;

    // Subtract pass: one byte digit of each delta per cycle, borrow carried.
    always_comb
    begin
        sub_p = {1'b0, pkt_reg[DIG_W-1:0]} - {1'b0, old_pkt_reg[DIG_W-1:0]}
              - (DIG_W+1)'(bor_p_reg);
        sub_b = {1'b0, byte_reg[DIG_W-1:0]} - {1'b0, old_byte_reg[DIG_W-1:0]}
              - (DIG_W+1)'(bor_b_reg);
    end

    // Multiply-add pass: apply the wrap fix to both deltas and form
    // packets times the signed overhead plus bytes, one digit per cycle.
    always_comb
    begin
        pinc = {1'b0, pkt_reg[DIG_W-1:0]} + (DIG_W+1)'(ctl.wrap_dig & bor_p_reg)
             + (DIG_W+1)'(c1_reg);
        prod = PROD_W'($signed({1'b0, pinc[DIG_W-1:0]})) * PROD_W'(overhead);
        acc  = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod}
             + ACC_W'(byte_reg[DIG_W-1:0])
             + ACC_W'(ctl.wrap_dig & bor_b_reg)
             + {{DIG_W{c2_reg[CARRY_W-1]}}, c2_reg};
    end

    // Divide pass: restoring division, two quotient bits per cycle.
    always_comb
    begin
        rem_tmp  = rem_reg;
        quo_bits = '0;
        rem_sh   = '0;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            rem_sh = {rem_tmp, byte_reg[WORD_W-1-k]};
            if (rem_sh >= {1'b0, divisor})
            begin
                rem_sh = rem_sh - {1'b0, divisor};
                quo_bits[DIV_BITS-1-k] = 1'b1;
            end
            rem_tmp = rem_sh[IVL_W-1:0];
        end
        rem_next = rem_tmp;
    end

    // Shift registers: the count words are reused for deltas and quotient.
    always_ff @(posedge clk)
    begin
        if (ctl.load_cur)
        begin
            pkt_reg  <= cur_packets;
            byte_reg <= cur_bytes;
        end
        else if (ctl.load_old)
        begin
            old_pkt_reg  <= old_packets;
            old_byte_reg <= old_bytes;
            bor_p_reg    <= 1'b0;
            bor_b_reg    <= 1'b0;
            c1_reg       <= 1'b0;
            c2_reg       <= '0;
            rem_reg      <= '0;
        end
        else if (ctl.sub_en)
        begin
            pkt_reg      <= {sub_p[DIG_W-1:0], pkt_reg[WORD_W-1:DIG_W]};
            byte_reg     <= {sub_b[DIG_W-1:0], byte_reg[WORD_W-1:DIG_W]};
            old_pkt_reg  <= {{DIG_W{1'b0}}, old_pkt_reg[WORD_W-1:DIG_W]};
            old_byte_reg <= {{DIG_W{1'b0}}, old_byte_reg[WORD_W-1:DIG_W]};
            bor_p_reg    <= sub_p[DIG_W];
            bor_b_reg    <= sub_b[DIG_W];
        end
        else if (ctl.mul_en)
        begin
            pkt_reg  <= {pinc[DIG_W-1:0], pkt_reg[WORD_W-1:DIG_W]};
            byte_reg <= {acc[DIG_W-1:0], byte_reg[WORD_W-1:DIG_W]};
            c1_reg   <= pinc[DIG_W];
            c2_reg   <= acc[ACC_W-1:DIG_W];
        end
        else if (ctl.div_en)
        begin
            byte_reg <= {byte_reg[WORD_W-1-DIV_BITS:0], quo_bits};
            rem_reg  <= rem_next;
        end
    end

    assign pkt_word  = pkt_reg;
    assign byte_word = byte_reg;

endmodule

// File: design/interface_rate_meter.sv
// Top level of the interface rate meter: sequencer, configuration and result register.
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_stall     port_index, rx/tx byte and packet counts
//   output    out        out_valid / out_stall   rx/tx bit rate, rx/tx packet delta, primed
//   config    in         cfg_write               cfg_index, cfg_data
//
// A sample passes through the store read, the load and two byte-serial passes
// (subtract, then multiply-add) to the radix-4 divider, 32 steps per 64-bit
// quotient; the next sample is taken only once the sequencer is back in idle.
// Reset clears the seen marks at once, so the sample store needs no clearing pass.
// A result waits in its register while out_stall is high; a finished sample
// holds in the last step until that register is free.
module interface_rate_meter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [irm_pkg::PORT_W-1:0]    port_index,
    input  logic [irm_pkg::WORD_W-1:0]    rx_byte_count,
    input  logic [irm_pkg::WORD_W-1:0]    rx_packet_count,
    input  logic [irm_pkg::WORD_W-1:0]    tx_byte_count,
    input  logic [irm_pkg::WORD_W-1:0]    tx_packet_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [irm_pkg::WORD_W-1:0]    rx_bit_rate,
    output logic [irm_pkg::WORD_W-1:0]    rx_packet_delta,
    output logic [irm_pkg::WORD_W-1:0]    tx_bit_rate,
    output logic [irm_pkg::WORD_W-1:0]    tx_packet_delta,
    output logic                          primed,
    input  logic                          cfg_write,
    input  logic [irm_pkg::CFG_AW-1:0]    cfg_index,
    input  logic [irm_pkg::IVL_W-1:0]     cfg_data
);
    import irm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_SUB  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [PORT_W-1:0]  port_reg;
    logic               primed_reg;
    logic [OVH_W-1:0]   ovh_reg;
    logic [IVL_W-1:0]   ivl_reg;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  rx_rate_reg;
    logic [WORD_W-1:0]  rx_delta_reg;
    logic [WORD_W-1:0]  tx_rate_reg;
    logic [WORD_W-1:0]  tx_delta_reg;
    logic               out_primed_reg;

    logic               in_xfer;
    logic               out_free;
    logic               in_range;
    logic               store_access;
    logic [IVL_W-1:0]   divisor;
    lane_ctl_t          ctl;
    sample_t            wdata;
    sample_t            rdata;
    logic               seen;
    logic [WORD_W-1:0]  rx_pkt_word;
    logic [WORD_W-1:0]  rx_byte_word;
    logic [WORD_W-1:0]  tx_pkt_word;
    logic [WORD_W-1:0]  tx_byte_word;

    // Handshake and entry range.
    assign in_stall     = (state_reg != S_IDLE);
    assign in_xfer      = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign in_range     = ({4'b0, port_reg} < 9'(NUM_PORTS));
    assign store_access = (state_reg == S_READ) && in_range;
    assign divisor      = (ivl_reg == '0) ? IVL_W'(1) : ivl_reg;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovh_reg <= OVERHEAD_RST;
            ivl_reg <= INTERVAL_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_OVERHEAD: ovh_reg <= cfg_data[OVH_W-1:0];
                REG_INTERVAL: ivl_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Sequencer next state and step counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + CNT_W'(1);
        unique case (state_reg)
            S_IDLE: if (in_xfer) state_next = S_READ;
            S_READ: state_next = S_LOAD;
            S_LOAD:
            begin
                state_next = S_SUB;
                cnt_next   = '0;
            end
            S_SUB:
            begin
                if (cnt_reg == CNT_W'(DIGITS - 1))
                begin
                    state_next = S_MUL;
                    cnt_next   = '0;
                end
            end
            S_MUL:
            begin
                if (cnt_reg == CNT_W'(DIGITS - 1))
                begin
                    state_next = S_DIV;
                    cnt_next   = '0;
                end
            end
            S_DIV: if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Sample tag and primed flag.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            port_reg <= port_index;
        if (state_reg == S_LOAD)
            primed_reg <= seen && in_range;
    end

    // Lane controls.
    always_comb
    begin
        ctl.load_cur = in_xfer;
        ctl.load_old = (state_reg == S_LOAD);
        ctl.sub_en   = (state_reg == S_SUB);
        ctl.mul_en   = (state_reg == S_MUL);
        ctl.div_en   = (state_reg == S_DIV);
        ctl.wrap_dig = (cnt_reg == CNT_W'(WRAP_DIGIT));
    end

    // The lanes still hold the new counts while the store is accessed.
    assign wdata.rx_bytes   = rx_byte_word;
    assign wdata.rx_packets = rx_pkt_word;
    assign wdata.tx_bytes   = tx_byte_word;
    assign wdata.tx_packets = tx_pkt_word;

    irm_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .access (store_access),
        .addr   (PORT_AW'(port_reg)),
        .wdata  (wdata),
        .rdata  (rdata),
        .seen   (seen)
    );

    irm_lane u_rx_lane (
        .clk         (clk),
        .ctl         (ctl),
        .cur_bytes   (rx_byte_count),
        .cur_packets (rx_packet_count),
        .old_bytes   (rdata.rx_bytes),
        .old_packets (rdata.rx_packets),
        .overhead    (ovh_reg),
        .divisor     (divisor),
        .pkt_word    (rx_pkt_word),
        .byte_word   (rx_byte_word)
    );

    irm_lane u_tx_lane (
        .clk         (clk),
        .ctl         (ctl),
        .cur_bytes   (tx_byte_count),
        .cur_packets (tx_packet_count),
        .old_bytes   (rdata.tx_bytes),
        .old_packets (rdata.tx_packets),
        .overhead    (ovh_reg),
        .divisor     (divisor),
        .pkt_word    (tx_pkt_word),
        .byte_word   (tx_byte_word)
    );

    // Result register; the rate is the quotient times eight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == S_DONE) && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_primed_reg <= primed_reg;
            rx_rate_reg    <= primed_reg ? {rx_byte_word[WORD_W-4:0], 3'b000} : '0;
            rx_delta_reg   <= primed_reg ? rx_pkt_word : '0;
            tx_rate_reg    <= primed_reg ? {tx_byte_word[WORD_W-4:0], 3'b000} : '0;
            tx_delta_reg   <= primed_reg ? tx_pkt_word : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign primed          = out_primed_reg;
    assign rx_bit_rate     = rx_rate_reg;
    assign rx_packet_delta = rx_delta_reg;
    assign tx_bit_rate     = tx_rate_reg;
    assign tx_packet_delta = tx_delta_reg;

    // A result appears only out of the final step.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_DONE)
        else $error("result register loaded outside the final step");

    // An unprimed result carries all-zero fields.
    a_unprimed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !primed) |-> (rx_bit_rate == '0 && rx_packet_delta == '0
            && tx_bit_rate == '0 && tx_packet_delta == '0))
        else $error("unprimed result has nonzero fields");

    // A transfer on the input starts the store access in the next cycle.
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == S_READ)
        else $error("input transfer did not start a store access");

    // The byte passes never run past the last digit.
    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUB || state_reg == S_MUL) |-> cnt_reg < CNT_W'(DIGITS))
        else $error("digit counter overran a byte pass");

endmodule
